// File: design/prime_field_arith_unit_macros.svh
// Assertion macros for the prime field arithmetic unit
`ifndef PRIME_FIELD_ARITH_UNIT_MACROS_SVH
`define PRIME_FIELD_ARITH_UNIT_MACROS_SVH

// same-cycle implication
`define PFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and codes of the prime field arithmetic unit.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int unsigned WordW = 31;
  localparam int unsigned ExpW  = 63;
  localparam int unsigned ModeW = 3;

  localparam logic [WordW-1:0] ModulusReset = 31'd1000000007;

  // operation codes
  localparam logic [ModeW-1:0] MODE_ADD = 3'd0;
  localparam logic [ModeW-1:0] MODE_SUB = 3'd1;
  localparam logic [ModeW-1:0] MODE_MUL = 3'd2;
  localparam logic [ModeW-1:0] MODE_POW = 3'd3;
  localparam logic [ModeW-1:0] MODE_DIV = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_POW_CHK,
    ST_POW_ACC,
    ST_POW_SQ,
    ST_FINAL,
    ST_DONE
  } state_e;

  // request to the modular multiplier
  typedef struct packed {
    logic             start;
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
  } mm_req_t;

  // response from the modular multiplier
  typedef struct packed {
    logic             done;
    logic [WordW-1:0] prod;
  } mm_rsp_t;

endpackage

// File: design/pfa_modmul.sv
// ----------------------------------------------------------------------------
// pfa_modmul
// Bit-serial interleaved modular multiplier: (x * y) mod m, one bit of y per
// cycle, MSB first. Requires x < m, or x = 1 for plain reduction of y.
// ----------------------------------------------------------------------------
module pfa_modmul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [pfa_pkg::WordW-1:0]  mod_i,
  input  pfa_pkg::mm_req_t           req_i,
  output pfa_pkg::mm_rsp_t           rsp_o
);

  localparam int unsigned CntW = $clog2(pfa_pkg::WordW);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [pfa_pkg::WordW-1:0] r_q, r_d;
  logic [pfa_pkg::WordW-1:0] x_q, x_d;
  logic [pfa_pkg::WordW-1:0] y_q, y_d;

  logic [pfa_pkg::WordW+1:0] t, t_m1, t_m2, m1, m2;
  logic [pfa_pkg::WordW-1:0] r_step;

  // one step: r = (2r + bit*x) mod m, with 2r + x < 3m
  always_comb begin
    m1     = {2'b00, mod_i};
    m2     = {1'b0, mod_i, 1'b0};
    t      = {1'b0, r_q, 1'b0} + (y_q[pfa_pkg::WordW-1] ? {2'b00, x_q} : '0);
    t_m1   = t - m1;
    t_m2   = t - m2;
    if (t >= m2) begin
      r_step = t_m2[pfa_pkg::WordW-1:0];
    end else if (t >= m1) begin
      r_step = t_m1[pfa_pkg::WordW-1:0];
    end else begin
      r_step = t[pfa_pkg::WordW-1:0];
    end
  end

  // step sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    x_d    = x_q;
    y_d    = y_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(pfa_pkg::WordW - 1);
      r_d    = '0;
      x_d    = req_i.x;
      y_d    = req_i.y;
    end else if (busy_q) begin
      r_d = r_step;
      y_d = {y_q[pfa_pkg::WordW-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    x_q <= x_d;
    y_q <= y_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = r_q;

endmodule

// File: design/prime_field_arith_unit.sv
// ----------------------------------------------------------------------------
// prime_field_arith_unit
// Add, subtract, multiply, power and Fermat divide modulo a configured prime.
// ----------------------------------------------------------------------------
// Usage: pulse start_i while busy_o is low; the item is taken at that edge and
// busy_o stays high until the residue appears on residue_o with a one-cycle
// result_valid_o strobe, which the receiver cannot stall. All work runs on one
// bit-serial modular multiplier. Both operands are first reduced through it.
// Multiply then adds one product; power and divide add a squaring per exponent
// bit and a product per set exponent bit, and divide a final product. The
// modulus must be written through the cfg channel only while the unit is idle;
// the unit itself does not enforce this. A modulus of 0 yields 0.
// ----------------------------------------------------------------------------
`include "prime_field_arith_unit_macros.svh"

module prime_field_arith_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [pfa_pkg::ModeW-1:0]   mode_i,
  input  logic [pfa_pkg::WordW-1:0]   operand_a_i,
  input  logic [pfa_pkg::WordW-1:0]   operand_b_i,
  input  logic [pfa_pkg::ExpW-1:0]    exponent_i,
  output logic                        result_valid_o,
  output logic [pfa_pkg::WordW-1:0]   residue_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pfa_pkg::WordW-1:0]   cfg_data_i
);

  pfa_pkg::state_e           state_q, state_d;
  logic [pfa_pkg::WordW-1:0] mod_q;
  logic [pfa_pkg::ModeW-1:0] mode_q;
  logic [pfa_pkg::WordW-1:0] a_q, b_q, acc_q, sq_q, res_q;
  logic [pfa_pkg::ExpW-1:0]  e_q;
  logic                      accept;

  pfa_pkg::mm_req_t mm_req;
  pfa_pkg::mm_rsp_t mm_rsp;

  logic [pfa_pkg::WordW:0]   sum, diff, sum_r, diff_r;
  logic [pfa_pkg::WordW-1:0] one_mod, div_exp;

  assign accept      = start_i && (state_q == pfa_pkg::ST_IDLE);
  assign busy_o      = (state_q != pfa_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // add / subtract of reduced operands (b arrives from the multiplier)
  always_comb begin
    sum    = {1'b0, a_q} + {1'b0, mm_rsp.prod};
    diff   = {1'b0, a_q} + {1'b0, mod_q} - {1'b0, mm_rsp.prod};
    sum_r  = (sum  >= {1'b0, mod_q}) ? sum  - {1'b0, mod_q} : sum;
    diff_r = (diff >= {1'b0, mod_q}) ? diff - {1'b0, mod_q} : diff;
    one_mod = (mod_q == pfa_pkg::WordW'(1)) ? '0 : pfa_pkg::WordW'(1);
    div_exp = (mod_q >= pfa_pkg::WordW'(2)) ? mod_q - pfa_pkg::WordW'(2) : '0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfa_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (mod_q == '0) ? pfa_pkg::ST_DONE : pfa_pkg::ST_RED_A;
        end
      end
      pfa_pkg::ST_RED_A: begin
        if (mm_rsp.done) state_d = pfa_pkg::ST_RED_B;
      end
      pfa_pkg::ST_RED_B: begin
        if (mm_rsp.done) begin
          case (mode_q)
            pfa_pkg::MODE_MUL: state_d = pfa_pkg::ST_FINAL;
            pfa_pkg::MODE_POW: state_d = pfa_pkg::ST_POW_CHK;
            pfa_pkg::MODE_DIV: state_d = pfa_pkg::ST_POW_CHK;
            default:           state_d = pfa_pkg::ST_DONE;
          endcase
        end
      end
      pfa_pkg::ST_POW_CHK: begin
        if (e_q == '0) begin
          state_d = (mode_q == pfa_pkg::MODE_DIV) ? pfa_pkg::ST_FINAL : pfa_pkg::ST_DONE;
        end else begin
          state_d = e_q[0] ? pfa_pkg::ST_POW_ACC : pfa_pkg::ST_POW_SQ;
        end
      end
      pfa_pkg::ST_POW_ACC: begin
        if (mm_rsp.done) state_d = pfa_pkg::ST_POW_SQ;
      end
      pfa_pkg::ST_POW_SQ: begin
        if (mm_rsp.done) state_d = pfa_pkg::ST_POW_CHK;
      end
      pfa_pkg::ST_FINAL: begin
        if (mm_rsp.done) state_d = pfa_pkg::ST_DONE;
      end
      pfa_pkg::ST_DONE: state_d = pfa_pkg::ST_IDLE;
      default:          state_d = pfa_pkg::ST_IDLE;
    endcase
  end

  // multiplier requests
  always_comb begin
    mm_req = '0;
    case (state_q)
      pfa_pkg::ST_IDLE: begin
        mm_req.start = accept && (mod_q != '0);
        mm_req.x     = pfa_pkg::WordW'(1);
        mm_req.y     = operand_a_i;
      end
      pfa_pkg::ST_RED_A: begin
        mm_req.start = mm_rsp.done;
        mm_req.x     = pfa_pkg::WordW'(1);
        mm_req.y     = b_q;
      end
      pfa_pkg::ST_RED_B: begin
        mm_req.start = mm_rsp.done && (mode_q == pfa_pkg::MODE_MUL);
        mm_req.x     = a_q;
        mm_req.y     = mm_rsp.prod;
      end
      pfa_pkg::ST_POW_CHK: begin
        if (e_q == '0) begin
          mm_req.start = (mode_q == pfa_pkg::MODE_DIV);
          mm_req.x     = a_q;
          mm_req.y     = acc_q;
        end else if (e_q[0]) begin
          mm_req.start = 1'b1;
          mm_req.x     = acc_q;
          mm_req.y     = sq_q;
        end else begin
          mm_req.start = 1'b1;
          mm_req.x     = sq_q;
          mm_req.y     = sq_q;
        end
      end
      pfa_pkg::ST_POW_ACC: begin
        mm_req.start = mm_rsp.done;
        mm_req.x     = sq_q;
        mm_req.y     = sq_q;
      end
      default: mm_req = '0;
    endcase
  end

  pfa_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mod_i  (mod_q),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfa_pkg::ST_IDLE;
      mod_q   <= pfa_pkg::ModulusReset;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) mod_q <= cfg_data_i;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      pfa_pkg::ST_IDLE: begin
        if (accept) begin
          mode_q <= mode_i;
          b_q    <= operand_b_i;
          e_q    <= exponent_i;
          res_q  <= '0;
        end
      end
      pfa_pkg::ST_RED_A: begin
        if (mm_rsp.done) a_q <= mm_rsp.prod;
      end
      pfa_pkg::ST_RED_B: begin
        if (mm_rsp.done) begin
          b_q   <= mm_rsp.prod;
          acc_q <= one_mod;
          sq_q  <= (mode_q == pfa_pkg::MODE_DIV) ? mm_rsp.prod : a_q;
          if (mode_q == pfa_pkg::MODE_DIV) e_q <= {{(pfa_pkg::ExpW-pfa_pkg::WordW){1'b0}}, div_exp};
          case (mode_q)
            pfa_pkg::MODE_ADD: res_q <= sum_r[pfa_pkg::WordW-1:0];
            pfa_pkg::MODE_SUB: res_q <= diff_r[pfa_pkg::WordW-1:0];
            default:           res_q <= '0;
          endcase
        end
      end
      pfa_pkg::ST_POW_CHK: begin
        if (e_q == '0) res_q <= acc_q;
      end
      pfa_pkg::ST_POW_ACC: begin
        if (mm_rsp.done) acc_q <= mm_rsp.prod;
      end
      pfa_pkg::ST_POW_SQ: begin
        if (mm_rsp.done) begin
          sq_q <= mm_rsp.prod;
          e_q  <= {1'b0, e_q[pfa_pkg::ExpW-1:1]};
        end
      end
      pfa_pkg::ST_FINAL: begin
        if (mm_rsp.done) res_q <= mm_rsp.prod;
      end
      default: ;
    endcase
  end

  assign result_valid_o = (state_q == pfa_pkg::ST_DONE);
  assign residue_o      = res_q;

  // checks
  `PFA_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, accept, busy_o, "accepted item did not raise busy")
  `PFA_ASSERT_NEXT(a_strobe_one, clk_i, rst_ni, result_valid_o, !result_valid_o && !busy_o,
                   "result strobe longer than one cycle")
  `PFA_ASSERT_NOW(a_res_range, clk_i, rst_ni, result_valid_o && (mod_q != '0), residue_o < mod_q,
                  "residue not below modulus")
  `PFA_ASSERT_NOW(a_mm_idle, clk_i, rst_ni, mm_rsp.done,
                  state_q != pfa_pkg::ST_IDLE && state_q != pfa_pkg::ST_DONE,
                  "multiplier finished outside a multiply state")

endmodule
